// ===== sv/nmea_chk_pkg.sv =====
`default_nettype none

package nmea_chk_pkg;

    // Longest sentence that still passes, in bytes without the line end.
    localparam int MaxLen    = 128;
    localparam int PrefixLen = 6;
    localparam int KindCount = 9;
    localparam int DataBytes = 5;

    localparam logic [7:0] CharDollar = 8'h24;
    localparam logic [7:0] CharStar   = 8'h2A;
    localparam logic [7:0] CharLf     = 8'h0A;
    localparam logic [7:0] CharCr     = 8'h0D;
    localparam logic [7:0] CountMax   = 8'hFF;

    // Reported kind when no prefix matches.
    localparam logic [3:0] KindNone = 4'd9;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_STAR  = 2'd1,
        STATUS_TOO_LONG = 2'd2,
        STATUS_MISMATCH = 2'd3
    } status_t;

    // Sentence prefixes in priority order; the first character sits in the top byte.
    localparam logic [8*PrefixLen-1:0] KIND_TABLE [KindCount] = '{
        "$GNGGA", "$GPGGA", "$GNGSA", "$GPGSA", "$GNRMC",
        "$GNVTG", "$GPGSV", "$GLGSV", "$GNGLL"
    };

    typedef struct packed {
        logic [7:0]           running_xor;
        logic                 star_seen;
        logic [7:0]           hex_value;
        logic                 hex_active;
        logic [7:0]           byte_count;
        logic [KindCount-1:0] prefix_alive;
    } sent_state_t;

    localparam sent_state_t SENT_CLEAR = '{
        running_xor:  8'h00,
        star_seen:    1'b0,
        hex_value:    8'h00,
        hex_active:   1'b0,
        byte_count:   8'h00,
        prefix_alive: {KindCount{1'b1}}
    };

    typedef struct packed {
        status_t    status;
        logic [3:0] sentence_kind;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
        logic [7:0] sentence_length;
        logic [7:0] error_total;
    } result_t;

    // Returns {is_digit, value}; both letter cases are taken.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = {1'b1, 4'(b - 8'h57)};
        end
        return d;
    endfunction

    // Folds one ordinary sentence byte into the running sentence state.
    function automatic sent_state_t take_byte(input sent_state_t s, input logic [7:0] b);
        sent_state_t n;
        logic [2:0]  pos;
        logic [4:0]  d;
        n   = s;
        pos = s.byte_count[2:0];
        d   = hex_digit(b);
        if (s.byte_count < 8'(PrefixLen)) begin
            for (int k = 0; k < KindCount; k++) begin
                if (KIND_TABLE[k][((PrefixLen - 1) - int'(pos)) * 8 +: 8] != b) begin
                    n.prefix_alive[k] = 1'b0;
                end
            end
        end
        if (s.byte_count != CountMax) begin
            n.byte_count = s.byte_count + 8'd1;
        end
        if (b == CharStar) begin
            n.star_seen  = 1'b1;
            n.hex_value  = 8'h00;
            n.hex_active = 1'b1;
        end else begin
            if (!s.star_seen && b != CharDollar) begin
                n.running_xor = s.running_xor ^ b;
            end
            if (s.hex_active) begin
                if (d[4]) begin
                    n.hex_value = {s.hex_value[3:0], d[3:0]};
                end else begin
                    n.hex_active = 1'b0;
                end
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== sv/nmea_chk_tracker.sv =====
`default_nettype none

module nmea_chk_tracker (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  byte_en,
    input  wire logic [7:0]            rx_byte,
    output nmea_chk_pkg::result_t      result
);
    import nmea_chk_pkg::*;

    sent_state_t sent_reg, sent_next;
    logic        cr_reg, cr_next;
    logic [7:0]  fail_reg, fail_next;

    sent_state_t after_cr;
    sent_state_t processed;
    logic        is_lf;
    logic        is_cr;
    status_t     status;
    logic [3:0]  kind;

    assign is_lf = (rx_byte == CharLf);
    assign is_cr = (rx_byte == CharCr);

    // A held CR counts as an ordinary byte unless the LF comes right after it.
    always_comb begin
        after_cr  = cr_reg ? take_byte(sent_reg, CharCr) : sent_reg;
        processed = is_cr ? after_cr : take_byte(after_cr, rx_byte);
    end

    always_comb begin
        if (sent_reg.byte_count > 8'(MaxLen)) begin
            status = STATUS_TOO_LONG;
        end else if (!sent_reg.star_seen) begin
            status = STATUS_NO_STAR;
        end else if (sent_reg.hex_value != sent_reg.running_xor) begin
            status = STATUS_MISMATCH;
        end else begin
            status = STATUS_OK;
        end
    end

    always_comb begin
        kind = KindNone;
        if (sent_reg.byte_count >= 8'(PrefixLen)) begin
            for (int k = KindCount - 1; k >= 0; k--) begin
                if (sent_reg.prefix_alive[k]) begin
                    kind = 4'(k);
                end
            end
        end
    end

    always_comb begin
        result.status          = status;
        result.sentence_kind   = kind;
        result.computed_sum    = sent_reg.running_xor;
        result.received_sum    = sent_reg.star_seen ? sent_reg.hex_value : 8'h00;
        result.sentence_length = sent_reg.byte_count;
        result.error_total     = (status != STATUS_OK) ? fail_reg + 8'd1 : fail_reg;
    end

    always_comb begin
        sent_next = sent_reg;
        cr_next   = cr_reg;
        fail_next = fail_reg;
        if (byte_en) begin
            if (is_lf) begin
                sent_next = SENT_CLEAR;
                cr_next   = 1'b0;
                fail_next = result.error_total;
            end else begin
                sent_next = processed;
                cr_next   = is_cr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg <= SENT_CLEAR;
            cr_reg   <= 1'b0;
            fail_reg <= 8'h00;
        end else begin
            sent_reg <= sent_next;
            cr_reg   <= cr_next;
            fail_reg <= fail_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nmea_sentence_checker_top.sv =====
// NMEA sentence checker.
// Received GPS characters arrive one per transfer on the s_ channel (s_tdata holds
// one byte). Each LF closes a sentence and produces one transfer on the m_ channel
// carrying the status, matched sentence kind, computed and received checksums,
// the sentence length and the running count of failed sentences. Other bytes
// produce no output transfer.
// A byte is captured in an input register at the edge where it is transferred and
// is folded into the sentence state from that register; for an LF the result register
// loads at that same edge, so m_tvalid rises as the LF leaves the input register.
// Throughput is one byte per cycle while no LF waits in the input register, set by
// the per-byte update of the sentence state; a held CR and the following byte are
// folded in the same cycle.
// When the receiver stalls, the result waits in the output register; ordinary
// bytes keep flowing, and only an LF waits in the input register until the
// pending result is taken, which in turn holds s_tready low.
// Reset (aresetn low, synchronous) empties both registers, clears the sentence
// state and clears the failed-sentence count.
`default_nettype none

module nmea_sentence_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [5:2] sentence_kind, [13:6] computed_sum, [21:14] received_sum,
    // [29:22] sentence_length, [37:30] error_total, [39:38] zero
    output      logic [8*nmea_chk_pkg::DataBytes-1:0] m_tdata
);
    import nmea_chk_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    result_t    result;
    logic       in_is_lf;
    logic       advance;

    assign in_is_lf = (in_byte_reg == CharLf);

    // Ordinary bytes never block; an LF needs room in the result register.
    assign advance  = in_valid_reg && (!in_is_lf || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    nmea_chk_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance && in_is_lf) begin
            out_valid_next = 1'b1;
            out_next       = result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.error_total,
                       out_reg.sentence_length,
                       out_reg.received_sum,
                       out_reg.computed_sum,
                       out_reg.sentence_kind,
                       out_reg.status};

    // A passing sentence always has matching checksums.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == STATUS_OK)
            |-> (out_reg.computed_sum == out_reg.received_sum))
        else $error("ok status with differing checksums");

    // Without a star there is no received checksum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == STATUS_NO_STAR) |-> (out_reg.received_sum == 8'h00))
        else $error("received checksum reported without a star");

    // A matched kind needs at least a full prefix.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.sentence_kind != KindNone)
            |-> (out_reg.sentence_length >= 8'(PrefixLen)))
        else $error("sentence kind matched on a short sentence");

    // Too long is reported exactly when the length exceeds the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_reg.status == STATUS_TOO_LONG)
                      == (out_reg.sentence_length > 8'(MaxLen))))
        else $error("too-long status disagrees with the length");

    // A new result is loaded only when the previous one is gone or leaving.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_is_lf) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== bench/nmea_report_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the sentence state and checks
// every result transfer against the oldest predicted sentence report.
module nmea_report_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] rx_byte
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] status, [5:2] sentence_kind, [13:6] computed_sum, [21:14] received_sum,
    // [29:22] sentence_length, [37:30] error_total, [39:38] zero
    input  logic [8*nmea_chk_pkg::DataBytes-1:0] m_tdata,
    output int                                   mismatch_total,
    output int                                   reports_waiting
);
    import nmea_chk_pkg::*;

    localparam logic [8*PrefixLen-1:0] PREFIX_TEXT [KindCount] = '{
        "$GNGGA", "$GPGGA", "$GNGSA", "$GPGSA", "$GNRMC",
        "$GNVTG", "$GPGSV", "$GLGSV", "$GNGLL"
    };

    typedef struct {
        status_t    status;
        logic [3:0] kind;
        logic [7:0] computed;
        logic [7:0] received;
        logic [7:0] length;
        logic [7:0] errors;
    } sentence_report_t;

    sentence_report_t expected_reports [$];

    logic [7:0]           xor_sum;
    logic                 star_hit;
    logic [7:0]           hex_acc;
    logic                 hex_on;
    logic [7:0]           char_count;
    logic                 cr_held;
    logic [KindCount-1:0] kind_alive;
    logic [7:0]           fail_tally;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        // Folding bit 5 maps upper case onto lower case.
        if ((c | 8'h20) >= "a" && (c | 8'h20) <= "f") begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

    task automatic clear_sentence();
        xor_sum    = 8'h00;
        star_hit   = 1'b0;
        hex_acc    = 8'h00;
        hex_on     = 1'b0;
        char_count = 8'h00;
        cr_held    = 1'b0;
        kind_alive = '1;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [4:0] nib;
        nib = hex_nibble(c);
        if (int'(char_count) < PrefixLen) begin
            for (int k = 0; k < KindCount; k++) begin
                if (PREFIX_TEXT[k][8*(PrefixLen-1-int'(char_count)) +: 8] != c) begin
                    kind_alive[k] = 1'b0;
                end
            end
        end
        if (char_count != 8'hFF) begin
            char_count = char_count + 8'd1;
        end
        if (c == CharStar) begin
            star_hit = 1'b1;
            hex_acc  = 8'h00;
            hex_on   = 1'b1;
        end else begin
            if (!star_hit && c != CharDollar) begin
                xor_sum = xor_sum ^ c;
            end
            if (hex_on) begin
                if (nib[4]) begin
                    hex_acc = {hex_acc[3:0], nib[3:0]};
                end else begin
                    hex_on = 1'b0;
                end
            end
        end
    endtask

    task automatic finish_sentence();
        sentence_report_t rep;
        if (int'(char_count) > MaxLen) begin
            rep.status = STATUS_TOO_LONG;
        end else if (!star_hit) begin
            rep.status = STATUS_NO_STAR;
        end else if (hex_acc != xor_sum) begin
            rep.status = STATUS_MISMATCH;
        end else begin
            rep.status = STATUS_OK;
        end
        rep.kind = KindNone;
        if (int'(char_count) >= PrefixLen) begin
            for (int k = KindCount - 1; k >= 0; k--) begin
                if (kind_alive[k]) begin
                    rep.kind = 4'(k);
                end
            end
        end
        if (rep.status != STATUS_OK) begin
            fail_tally = fail_tally + 8'd1;
        end
        rep.computed = xor_sum;
        rep.received = star_hit ? hex_acc : 8'h00;
        rep.length   = char_count;
        rep.errors   = fail_tally;
        expected_reports.push_back(rep);
        clear_sentence();
    endtask

    // A CR is held until the next byte shows whether it ends the line.
    task automatic take_rx(input logic [7:0] c);
        if (c == CharLf) begin
            finish_sentence();
        end else begin
            if (cr_held) begin
                cr_held = 1'b0;
                absorb_char(CharCr);
            end
            if (c == CharCr) begin
                cr_held = 1'b1;
            end else begin
                absorb_char(c);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s differs, expected %02h, actual %02h",
                     $time, what, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        sentence_report_t due;
        if (!aresetn) begin
            clear_sentence();
            fail_tally = 8'h00;
            expected_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                take_rx(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: result transfer, expected none, actual %010h",
                             $time, m_tdata);
                    mismatch_total++;
                end else begin
                    due = expected_reports.pop_front();
                    check_field("status", 8'(due.status), 8'(m_tdata[1:0]));
                    check_field("sentence_kind", 8'(due.kind), 8'(m_tdata[5:2]));
                    check_field("computed_sum", due.computed, m_tdata[13:6]);
                    check_field("received_sum", due.received, m_tdata[21:14]);
                    check_field("sentence_length", due.length, m_tdata[29:22]);
                    check_field("error_total", due.errors, m_tdata[37:30]);
                    check_field("padding", 8'h00, 8'(m_tdata[39:38]));
                end
            end
        end
        reports_waiting <= expected_reports.size();
    end

endmodule

// ===== bench/nmea_sentence_checker_top_tb.sv =====
`timescale 1ns / 100ps

// Drives NMEA character streams into the sentence checker and gives the verdict.
// Prediction and comparison live in the report checker instantiated beside the block.
module nmea_sentence_checker_top_tb;
    import nmea_chk_pkg::*;

    // Generous bound on the whole run; the slowest correct run is far below it.
    localparam int CycleLimit  = 200000;
    // Length of the receiver hold-off that fills the block up.
    localparam int HoldCycles  = 300;
    // Random characters offered per idling phase.
    localparam int PhaseChars  = 25;
    // Quiet cycles after the last result, covering the result latency with margin.
    localparam int DrainCycles = 8;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [8*DataBytes-1:0] m_tdata;

    int mismatch_total;
    int reports_waiting;

    // Idling percentages; the receiver process reads the stall figure whenever no hold-off is pending or running.
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // The stimulus asks for a hold-off by bumping the request count; the receiver
    // process serves each request and counts the stalled cycles itself.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int cycle_count = 0;
    int chars_sent  = 0;

    // Characters of the line being assembled before it is offered.
    logic [7:0] line_bytes [$];

    string sentence_heads [KindCount] = '{
        "$GNGGA", "$GPGGA", "$GNGSA", "$GPGSA", "$GNRMC",
        "$GNVTG", "$GPGSV", "$GLGSV", "$GNGLL"
    };

    // Characters typical of sentence fields, with a stray dollar sign.
    string field_chars = "0123456789,.,,NSEWMABCDEFabcdef$";

    nmea_sentence_checker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nmea_report_checker u_report_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_total  (mismatch_total),
        .reports_waiting (reports_waiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: a pending hold-off wins; otherwise ready is drawn at random
    // against the current stall percentage.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= HoldCycles;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offers one character and returns at the edge where its transfer happens.
    // Valid only drops during idle gaps before a character, so it never toggles within one step.
    task automatic offer_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        chars_sent++;
    endtask

    // Stops offering and waits until the checker has no report outstanding.
    // The first edge lets a just-accepted LF show up in the count.
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_waiting != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            line_bytes.push_back(t[i]);
        end
    endtask

    task automatic push_fill(input logic [7:0] c, input int n);
        repeat (n) line_bytes.push_back(c);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    // Appends a star and two hex digits that carry the checksum of the line so
    // far, or a deliberately wrong one.
    task automatic push_checksum(input bit corrupt, input bit lower);
        logic [7:0] sum;
        sum = 8'h00;
        foreach (line_bytes[i]) begin
            if (line_bytes[i] != CharDollar) begin
                sum = sum ^ line_bytes[i];
            end
        end
        if (corrupt) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        line_bytes.push_back(CharStar);
        line_bytes.push_back(hex_char(sum[7:4], lower));
        line_bytes.push_back(hex_char(sum[3:0], lower));
    endtask

    // Ends the line with LF (0), CR LF (1) or CR CR LF (2) and offers it whole.
    task automatic close_line(input int ending);
        if (ending == 2) begin
            line_bytes.push_back(CharCr);
        end
        if (ending != 0) begin
            line_bytes.push_back(CharCr);
        end
        line_bytes.push_back(CharLf);
        foreach (line_bytes[i]) begin
            offer_char(line_bytes[i]);
        end
        line_bytes.delete();
    endtask

    // Mostly field characters; now and then a CR inside the line or any byte
    // other than LF and star.
    function automatic logic [7:0] random_body_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            return CharCr;
        end
        if (r < 6) begin
            c = 8'($urandom_range(0, 255));
            while (c == CharLf || c == CharStar) begin
                c = 8'($urandom_range(0, 255));
            end
            return c;
        end
        return field_chars[$urandom_range(0, field_chars.len() - 1)];
    endfunction

    // Many lines are well-formed sentences with random fields; the rest have a
    // broken prefix, a broken tail, no star, an overlong body, or are pure byte noise.
    task automatic send_random_line();
        int    r;
        int    body_len;
        int    ending;
        string head;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            close_line(0);
        end else begin
            head = sentence_heads[$urandom_range(0, KindCount - 1)];
            r = $urandom_range(0, 99);
            if (r < 10) begin
                head = "$GPRMC";
            end else if (r < 20) begin
                head = head.substr(0, $urandom_range(0, 4));
            end
            push_text(head);
            if (r >= 20 && r < 30) begin
                line_bytes[$urandom_range(0, head.len() - 1)] = 8'($urandom_range(32, 126));
            end

            // Short bodies keep results frequent; a few run past the length
            // limit and fewer still past the counter's saturation point.
            r = $urandom_range(0, 99);
            if (r < 94) begin
                body_len = $urandom_range(0, 30);
            end else if (r < 99) begin
                body_len = $urandom_range(110, 135);
            end else begin
                body_len = $urandom_range(250, 300);
            end
            repeat (body_len) line_bytes.push_back(random_body_char());

            r = $urandom_range(0, 99);
            if (r < 75) begin
                push_checksum($urandom_range(0, 99) < 20, 1'($urandom_range(0, 1)));
            end else if (r < 85) begin
                line_bytes.push_back(CharStar);
                repeat ($urandom_range(0, 4)) begin
                    line_bytes.push_back(hex_char(4'($urandom_range(0, 15)),
                                                  1'($urandom_range(0, 1))));
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_text(",Z9");
                end
            end else if (r < 92) begin
                push_checksum(1'b0, 1'b0);
                line_bytes.push_back(CharStar);
                line_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                line_bytes.push_back(hex_char(4'($urandom_range(0, 15)), 1'b1));
            end

            r = $urandom_range(0, 99);
            ending = (r < 70) ? 1 : ((r < 90) ? 0 : 2);
            close_line(ending);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty lines: length zero, no star, no kind.
        close_line(0);
        close_line(1);

        // Every sentence kind once, one of them with a bad checksum, with
        // upper and lower case hex digits.
        for (int k = 0; k < KindCount; k++) begin
            push_text(sentence_heads[k]);
            push_text(",1");
            push_checksum(k == 3, k[0]);
            close_line(1);
        end

        // Unknown prefix, and a prefix cut short so that no kind matches.
        push_text("$GPRMC,1");
        push_checksum(1'b0, 1'b0);
        close_line(1);
        push_text("$GNG");
        push_checksum(1'b0, 1'b0);
        close_line(0);

        // Exactly six bytes: the kind matches even though the star is missing.
        push_text("$GNGGA");
        close_line(0);

        // A CR inside the line counts as an ordinary byte; of two CRs before
        // the LF only the last one is dropped.
        push_text("$GN");
        line_bytes.push_back(CharCr);
        push_text("GGA,5");
        push_checksum(1'b0, 1'b0);
        close_line(2);

        // Dollar signs inside the sentence stay out of the computed sum.
        push_text("$GPGSA,$1,$");
        push_checksum(1'b0, 1'b1);
        close_line(1);

        // A second star restarts the received sum; the computed sum stops at
        // the first star.
        push_text("$GNVTG,0");
        push_checksum(1'b0, 1'b0);
        push_text("*3f");
        close_line(1);

        // Three digits keep the low byte; a non-hex byte ends the digits;
        // a bare star and a 0x prefix give zero.
        push_text("$GPGSV,1*1AB");
        close_line(1);
        push_text("$GLGSV,2*4G7");
        close_line(0);
        push_text("$GNGSA*");
        close_line(1);
        push_text("$GNGLL*0x1F");
        close_line(1);

        // Extreme byte values are ordinary characters.
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h80);
        line_bytes.push_back(8'h7F);
        close_line(0);

        // Longest sentence that may still pass, then one byte longer.
        push_text("$GPGGA,");
        push_fill(8'h37, MaxLen - 10);
        push_checksum(1'b0, 1'b0);
        close_line(1);
        push_text("$GPGGA,");
        push_fill(8'h37, MaxLen - 9);
        push_checksum(1'b0, 1'b0);
        close_line(1);

        // Long enough for the length to saturate.
        push_text("$GNGLL,");
        push_fill(8'h30, 250);
        push_checksum(1'b0, 1'b0);
        close_line(1);

        // A run of empty lines takes the failure count through its wrap.
        for (int n = 0; n < 260; n++) begin
            close_line(0);
        end
        push_text("$GNRMC,9");
        push_checksum(1'b0, 1'b1);
        close_line(1);
        wait_for_reports();

        // Random lines under each idling mix; the sender drains all results
        // between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct   = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_gap_pct   = 18;
                    recv_stall_pct = 18;
                end
            endcase
            chars_sent = 0;
            while (chars_sent < PhaseChars) begin
                send_random_line();
            end
            if (phase == 0) begin
                // The receiver holds off while lines keep coming, so a second
                // LF finds the output register full and stalls the input.
                hold_requests++;
                repeat (2) send_random_line();
            end
            wait_for_reports();
        end

        repeat (DrainCycles) @(posedge aclk);
        if (mismatch_total == 0 && reports_waiting == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/nmea_chk_pkg.sv
sv/nmea_chk_tracker.sv
sv/nmea_sentence_checker_top.sv
bench/nmea_report_checker.sv
bench/nmea_sentence_checker_top_tb.sv
